@@ rtl/gh_pkg.sv @@
package gh_pkg;

  localparam int IN_TDATA_W  = 112;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 4;
  localparam int DIV_W       = 17;

  localparam logic [1:0] OP_LOAD_BLOOM  = 2'd0;
  localparam logic [1:0] OP_LOAD_BUCKET = 2'd1;
  localparam logic [1:0] OP_LOAD_CHAIN  = 2'd2;
  localparam logic [1:0] OP_LOOKUP      = 2'd3;

  localparam logic [2:0] OUT_CHAIN_END = 3'd0;
  localparam logic [2:0] OUT_BLOOM_REJ = 3'd1;
  localparam logic [2:0] OUT_EMPTY     = 3'd2;
  localparam logic [2:0] OUT_RANGE     = 3'd3;
  localparam logic [2:0] OUT_TRUNC     = 3'd4;

  localparam logic [1:0] REG_BLOOM_COUNT  = 2'd0;
  localparam logic [1:0] REG_SHIFT        = 2'd1;
  localparam logic [1:0] REG_BUCKET_COUNT = 2'd2;
  localparam logic [1:0] REG_FIRST_SYM    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_WORD,
    ST_DIV_BUCK,
    ST_TBL_RD,
    ST_TBL_CHK,
    ST_CH_ADDR,
    ST_CH_DATA
  } state_t;

endpackage

@@ rtl/gh_ram.sv @@
module gh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/gnu_hash_symbol_lookup_core.sv @@
// GNU hash table lookup engine.
// Input stream: in_tuser carries the opcode; load bloom word, load bucket and
// load chain value write one entry of on-chip RAM and give no result. A lookup
// tests two bloom bits, reads the bucket head and walks the chain, sending one
// transfer per matching symbol index (tuser bit 0 set) and a closing transfer
// with tlast high and the outcome code in tuser.
// Configuration: cfg_we writes register cfg_index (0 bloom word count,
// 1 second hash shift, 2 bucket count, 3 first hashed symbol). The user must
// write only while idle; the block itself does not enforce it. A lookup runs
// two 32-step remainder calculations on one shared bit-serial divider, then
// the bloom and bucket reads, then walks the chain through the single chain
// RAM read port, with an address and a data state per entry and one more data
// state per candidate. in_tready is high only between lookups.
// Stalls: results sit in an output register; when out_tready is low the walk
// waits on it, and a new item can be taken while the last result waits.
// Reset clears the control state and the registers to their defaults; the RAM
// contents are undefined until loaded.
module gnu_hash_symbol_lookup_core #(
  parameter int BLOOM_DEPTH    = 256,
  parameter int BUCKET_DEPTH   = 1024,
  parameter int CHAIN_DEPTH    = 4096,
  parameter int MAX_CANDIDATES = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // table_index[11:0], table_data[75:12], symbol_hash[107:76], zero pad
  input  logic [gh_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [gh_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // symbol_index[31:0]
  output logic [gh_pkg::OUT_TDATA_W-1:0] out_tdata,
  // is_candidate[0], outcome[3:1]
  output logic [gh_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int BAW = (BLOOM_DEPTH > 1) ? $clog2(BLOOM_DEPTH) : 1;
  localparam int KAW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CAW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int DW  = gh_pkg::DIV_W;

  // configuration
  logic [8:0]  bwc_r;
  logic [4:0]  shift_r;
  logic [10:0] bkc_r;
  logic [31:0] fhs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bwc_r   <= 9'd1;
      shift_r <= 5'd0;
      bkc_r   <= 11'd1;
      fhs_r   <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gh_pkg::REG_BLOOM_COUNT:  bwc_r   <= cfg_wdata[8:0];
        gh_pkg::REG_SHIFT:        shift_r <= cfg_wdata[4:0];
        gh_pkg::REG_BUCKET_COUNT: bkc_r   <= cfg_wdata[10:0];
        gh_pkg::REG_FIRST_SYM:    fhs_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // counts of zero act as one, oversized counts as the store depth
  logic [DW-1:0] nwords, nbuck;
  always_comb begin
    nwords = DW'(bwc_r);
    if (bwc_r == 9'd0) nwords = DW'(1);
    else if (nwords > DW'(BLOOM_DEPTH)) nwords = DW'(BLOOM_DEPTH);
    nbuck = DW'(bkc_r);
    if (bkc_r == 11'd0) nbuck = DW'(1);
    else if (nbuck > DW'(BUCKET_DEPTH)) nbuck = DW'(BUCKET_DEPTH);
  end

  // input fields
  logic [1:0]  in_op;
  logic [11:0] in_ti;
  logic [63:0] in_data;
  logic [31:0] in_hash;
  logic [31:0] ti_ext;
  assign in_op   = in_tuser[1:0];
  assign in_ti   = in_tdata[11:0];
  assign in_data = in_tdata[75:12];
  assign in_hash = in_tdata[107:76];
  assign ti_ext  = {20'd0, in_ti};

  // state
  gh_pkg::state_t state_r, state_nxt;
  logic [31:0]   hash_r, hash_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [DW-1:0] word_r, word_nxt;
  logic [DW-1:0] buck_r, buck_nxt;
  logic [31:0]   idx_r, idx_nxt;
  logic [5:0]    n_r, n_nxt;
  logic          cand_done_r, cand_done_nxt;

  logic                          out_tvalid_r;
  logic [gh_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [gh_pkg::OUT_TUSER_W-1:0] out_tuser_r;
  logic                          out_tlast_r;

  logic in_acc, out_free;
  assign in_tready = (state_r == gh_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // memories
  logic        bl_we, bk_we, ch_we, tbl_re, ch_re;
  logic [63:0] bl_rdata;
  logic [31:0] bk_rdata, ch_rdata;
  logic [31:0] pos;

  assign bl_we = in_acc && in_op == gh_pkg::OP_LOAD_BLOOM  && ti_ext < 32'(BLOOM_DEPTH);
  assign bk_we = in_acc && in_op == gh_pkg::OP_LOAD_BUCKET && ti_ext < 32'(BUCKET_DEPTH);
  assign ch_we = in_acc && in_op == gh_pkg::OP_LOAD_CHAIN  && ti_ext < 32'(CHAIN_DEPTH);

  gh_ram #(.WIDTH(64), .DEPTH(BLOOM_DEPTH)) u_bloom (
    .clk(clk), .we(bl_we), .waddr(ti_ext[BAW-1:0]), .wdata(in_data),
    .re(tbl_re), .raddr(word_r[BAW-1:0]), .rdata(bl_rdata)
  );

  gh_ram #(.WIDTH(32), .DEPTH(BUCKET_DEPTH)) u_bucket (
    .clk(clk), .we(bk_we), .waddr(ti_ext[KAW-1:0]), .wdata(in_data[31:0]),
    .re(tbl_re), .raddr(buck_r[KAW-1:0]), .rdata(bk_rdata)
  );

  gh_ram #(.WIDTH(32), .DEPTH(CHAIN_DEPTH)) u_chain (
    .clk(clk), .we(ch_we), .waddr(ti_ext[CAW-1:0]), .wdata(in_data[31:0]),
    .re(ch_re), .raddr(pos[CAW-1:0]), .rdata(ch_rdata)
  );

  // shared restoring divider step, one quotient bit a cycle
  logic [DW-1:0] divisor, rem_step;
  logic [DW:0]   div_t, div_sub;
  logic          div_ge;
  assign divisor  = (state_r == gh_pkg::ST_DIV_WORD) ? nwords : nbuck;
  assign div_t    = {rem_r, q_r[31]};
  assign div_sub  = div_t - {1'b0, divisor};
  assign div_ge   = div_t >= {1'b0, divisor};
  assign rem_step = div_ge ? div_sub[DW-1:0] : div_t[DW-1:0];

  // decisions
  logic [31:0] h2;
  logic        bloom_ok, head_zero, range_bad, match, at_max, trunc;
  assign h2        = hash_r >> shift_r;
  assign bloom_ok  = bl_rdata[hash_r[5:0]] && bl_rdata[h2[5:0]];
  assign head_zero = (bk_rdata == 32'd0);
  assign pos       = idx_r - fhs_r;
  assign range_bad = (idx_r < fhs_r) || ({1'b0, pos} >= 33'(CHAIN_DEPTH));
  assign match     = (ch_rdata[31:1] == hash_r[31:1]) && !cand_done_r;
  assign at_max    = (idx_r == 32'hFFFF_FFFF);
  assign trunc     = n_r >= 6'(MAX_CANDIDATES);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gh_pkg::ST_IDLE: begin
        if (in_acc && in_op == gh_pkg::OP_LOOKUP) state_nxt = gh_pkg::ST_DIV_WORD;
      end
      gh_pkg::ST_DIV_WORD: begin
        if (cnt_r == 5'd0) state_nxt = gh_pkg::ST_DIV_BUCK;
      end
      gh_pkg::ST_DIV_BUCK: begin
        if (cnt_r == 5'd0) state_nxt = gh_pkg::ST_TBL_RD;
      end
      gh_pkg::ST_TBL_RD: state_nxt = gh_pkg::ST_TBL_CHK;
      gh_pkg::ST_TBL_CHK: begin
        if (!bloom_ok || head_zero) begin
          if (out_free) state_nxt = gh_pkg::ST_IDLE;
        end else begin
          state_nxt = gh_pkg::ST_CH_ADDR;
        end
      end
      gh_pkg::ST_CH_ADDR: begin
        if (!range_bad) state_nxt = gh_pkg::ST_CH_DATA;
        else if (out_free) state_nxt = gh_pkg::ST_IDLE;
      end
      gh_pkg::ST_CH_DATA: begin
        if (match) begin
          if (trunc && out_free) state_nxt = gh_pkg::ST_IDLE;
        end else if (ch_rdata[0] || at_max) begin
          if (out_free) state_nxt = gh_pkg::ST_IDLE;
        end else begin
          state_nxt = gh_pkg::ST_CH_ADDR;
        end
      end
      default: state_nxt = gh_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  logic        emit, emit_cand, emit_last;
  logic [31:0] emit_idx;
  logic [2:0]  emit_code;

  always_comb begin
    hash_nxt      = hash_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    word_nxt      = word_r;
    buck_nxt      = buck_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    cand_done_nxt = cand_done_r;
    tbl_re        = 1'b0;
    ch_re         = 1'b0;
    emit          = 1'b0;
    emit_cand     = 1'b0;
    emit_last     = 1'b1;
    emit_idx      = 32'd0;
    emit_code     = gh_pkg::OUT_CHAIN_END;
    unique case (state_r)
      gh_pkg::ST_IDLE: begin
        if (in_acc && in_op == gh_pkg::OP_LOOKUP) begin
          hash_nxt = in_hash;
          q_nxt    = {6'd0, in_hash[31:6]};
          rem_nxt  = '0;
          cnt_nxt  = 5'd31;
          n_nxt    = 6'd0;
        end
      end
      gh_pkg::ST_DIV_WORD, gh_pkg::ST_DIV_BUCK: begin
        q_nxt   = {q_r[30:0], 1'b0};
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          if (state_r == gh_pkg::ST_DIV_WORD) begin
            word_nxt = rem_step;
            q_nxt    = hash_r;
            rem_nxt  = '0;
            cnt_nxt  = 5'd31;
          end else begin
            buck_nxt = rem_step;
          end
        end
      end
      gh_pkg::ST_TBL_RD: tbl_re = 1'b1;
      gh_pkg::ST_TBL_CHK: begin
        if (!bloom_ok) begin
          emit      = out_free;
          emit_code = gh_pkg::OUT_BLOOM_REJ;
        end else if (head_zero) begin
          emit      = out_free;
          emit_code = gh_pkg::OUT_EMPTY;
        end else begin
          idx_nxt       = bk_rdata;
          cand_done_nxt = 1'b0;
        end
      end
      gh_pkg::ST_CH_ADDR: begin
        if (range_bad) begin
          emit      = out_free;
          emit_idx  = idx_r;
          emit_code = gh_pkg::OUT_RANGE;
        end else begin
          ch_re = 1'b1;
        end
      end
      gh_pkg::ST_CH_DATA: begin
        emit_idx = idx_r;
        if (match) begin
          emit = out_free;
          if (trunc) begin
            emit_code = gh_pkg::OUT_TRUNC;
          end else begin
            emit_cand = 1'b1;
            emit_last = 1'b0;
            if (out_free) begin
              n_nxt         = n_r + 6'd1;
              cand_done_nxt = 1'b1;
            end
          end
        end else if (ch_rdata[0]) begin
          emit = out_free;
        end else if (at_max) begin
          emit      = out_free;
          emit_idx  = 32'd0;
          emit_code = gh_pkg::OUT_RANGE;
        end else begin
          idx_nxt       = idx_r + 32'd1;
          cand_done_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gh_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
      n_r          <= 6'd0;
      cand_done_r  <= 1'b0;
      cnt_r        <= 5'd0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      cand_done_r <= cand_done_nxt;
      cnt_r       <= cnt_nxt;
      if (emit) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    word_r <= word_nxt;
    buck_r <= buck_nxt;
    idx_r  <= idx_nxt;
    if (emit) begin
      out_tdata_r <= emit_idx;
      out_tuser_r <= {emit_code, emit_cand};
      out_tlast_r <= emit_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  a_cand_count: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 6'(MAX_CANDIDATES))
    else $error("candidate count beyond limit");

  a_cand_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_cand) |-> (state_r == gh_pkg::ST_CH_DATA && !emit_last))
    else $error("candidate outside chain walk");

  a_lookup_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == gh_pkg::OP_LOOKUP) |=> (state_r == gh_pkg::ST_DIV_WORD))
    else $error("lookup did not start divider");

  a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gh_pkg::ST_TBL_RD) |-> (word_r < nwords && buck_r < nbuck))
    else $error("remainder not below divisor");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result dropped on full output register");

endmodule
